// File: hw/rtl/multi_tone_sine_synthesizer_macros.svh
// Assertion macros shared by the multi-tone synthesizer RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef MULTI_TONE_SINE_SYNTHESIZER_MACROS_SVH
`define MULTI_TONE_SINE_SYNTHESIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mts_pkg.sv
// Shared constants, types and the sine table builder for the multi-tone synthesizer.
// Used by the controller, the datapath, the sine lookup and the top level.
package mts_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_MAX_TONES  = 4;
    localparam int DEF_TABLE_BITS = 10;
    localparam int DEF_ACC_BITS   = 24;

    // Configuration port.
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 57;
    localparam int NUM_TONE_WORDS = 4;
    localparam int COUNT_W        = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_TONE_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE0      = 3'd1;

    localparam logic [COUNT_W-1:0]    COUNT_RESET = 3'd1;
    localparam logic [CFG_DATA_W-1:0] WORD_RESET  = 57'd1073742080;

    // Tone word packing.
    localparam int COS_BIT   = 56;
    localparam int PHASE_LSB = 40;
    localparam int PHASE_W   = 16;
    localparam int TUNE_LSB  = 16;
    localparam int TUNE_W    = 24;
    localparam int AMP_W     = 16;

    // Sine values are signed Q1.14, magnitudes fit in 15 bits.
    localparam int SINE_W     = 16;
    localparam int SINE_MAG_W = 15;
    localparam logic [SINE_MAG_W-1:0] SINE_ONE = 15'd16384;
    localparam int PROD_W     = AMP_W + SINE_W;

    // Output rounding and saturation.
    localparam int SAMPLE_W   = 19;
    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_HALF = 8192;
    localparam int SAMPLE_MAX = 262143;
    localparam int SAMPLE_MIN = -262144;

    // Pi in Q2.30 for the table builder.
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic clear_acc;
        logic issue;
        logic advance;
        logic load_out;
    } mts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
    } mts_status_t;

    // Two Q2.30 multiplications by x, as in one Taylor term step.
    function automatic longint unsigned sq_step(input longint unsigned term,
                                                input longint unsigned x);
        longint unsigned t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Quarter-wave sine in Q1.14 for entry j of a table with 2^tbits entries.
    // Evaluated only at elaboration, to build the constant table.
    function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned j,
                                                           input int tbits);
        longint unsigned x;
        longint unsigned term;
        longint sum;
        longint v;
        x    = (PI_Q30 * 64'd2 * longint'(j)) >> tbits;
        term = x;
        sum  = longint'(x);
        term = sq_step(term, x) / 64'd6;   sum = sum - longint'(term);
        term = sq_step(term, x) / 64'd20;  sum = sum + longint'(term);
        term = sq_step(term, x) / 64'd42;  sum = sum - longint'(term);
        term = sq_step(term, x) / 64'd72;  sum = sum + longint'(term);
        term = sq_step(term, x) / 64'd110; sum = sum - longint'(term);
        term = sq_step(term, x) / 64'd156; sum = sum + longint'(term);
        term = sq_step(term, x) / 64'd210; sum = sum - longint'(term);
        term = sq_step(term, x) / 64'd272; sum = sum + longint'(term);
        term = sq_step(term, x) / 64'd342; sum = sum - longint'(term);
        term = sq_step(term, x) / 64'd420; sum = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (sum + 32768) >>> 16;
        if (v > 16384)
        begin
            v = 16384;
        end
        return SINE_MAG_W'(v);
    endfunction

endpackage

// File: hw/rtl/mts_sine_lut.sv
// Full-turn sine lookup built from a quarter-wave constant table.
// Depends on mts_pkg for the table builder and sine widths.
module mts_sine_lut #(
    parameter int TABLE_BITS = mts_pkg::DEF_TABLE_BITS
) (
    input  logic [TABLE_BITS-1:0]             idx,
    output logic signed [mts_pkg::SINE_W-1:0] value
);
    import mts_pkg::*;

    localparam int QUARTER = 2 ** (TABLE_BITS - 2);
    localparam int QIDX_W  = TABLE_BITS - 2;

    typedef logic [QUARTER-1:0][SINE_MAG_W-1:0] qtab_t;

    // The quarter table holds entries 0 .. QUARTER-1; entry QUARTER is exactly one.
    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int j = 0; j < QUARTER; j++)
        begin
            t[j] = quarter_sine(j, TABLE_BITS);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    logic [1:0]              quadrant;
    logic [QIDX_W-1:0]       rem_idx;
    logic [QIDX_W:0]         fold_idx;
    logic [SINE_MAG_W-1:0]   mag;
    logic signed [SINE_W-1:0] mag_s;

    // Mirror the index in odd quadrants and negate in the second half turn.
    always_comb
    begin
        quadrant = idx[TABLE_BITS-1 -: 2];
        rem_idx  = idx[QIDX_W-1:0];
        fold_idx = {1'b0, rem_idx};
        if (quadrant[0])
        begin
            fold_idx = (QIDX_W+1)'(QUARTER) - {1'b0, rem_idx};
        end
        if (fold_idx[QIDX_W])
        begin
            mag = SINE_ONE;
        end
        else
        begin
            mag = QTAB[fold_idx[QIDX_W-1:0]];
        end
        mag_s = $signed({1'b0, mag});
        value = quadrant[1] ? -mag_s : mag_s;
    end

endmodule

// File: hw/rtl/mts_dp.sv
// Datapath: tone registers, phase accumulators, lookup/multiply pipeline, output register.
// Depends on mts_pkg, mts_sine_lut and the assertion macro header.
`include "multi_tone_sine_synthesizer_macros.svh"

module mts_dp #(
    parameter int MAX_TONES  = mts_pkg::DEF_MAX_TONES,
    parameter int TABLE_BITS = mts_pkg::DEF_TABLE_BITS,
    parameter int ACC_BITS   = mts_pkg::DEF_ACC_BITS,
    parameter int TI_W       = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr,
    input  logic [mts_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  mts_pkg::mts_cmd_t                  cmd,
    input  logic [TI_W-1:0]                    tone_idx,
    output mts_pkg::mts_status_t               status,
    output logic signed [mts_pkg::SAMPLE_W-1:0] sample
);
    import mts_pkg::*;

    localparam int SUM_W = PROD_W + $clog2(MAX_TONES) + 1;
    localparam int SH_W  = SUM_W - FRAC_SHIFT;
    localparam logic [ACC_BITS-1:0] QTR_TURN = ACC_BITS'(1) << (ACC_BITS - 2);
    localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(SAMPLE_MAX);
    localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(SAMPLE_MIN);
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(ROUND_HALF);

    logic [CFG_DATA_W-1:0] tone_word_reg [MAX_TONES];
    logic [ACC_BITS-1:0]   acc_reg [MAX_TONES];

    logic [CFG_DATA_W-1:0] sel_word;
    logic [ACC_BITS-1:0]   angle;

    logic                         v0_reg, v1_reg, v2_reg;
    logic [TABLE_BITS-1:0]        idx0_reg;
    logic signed [AMP_W-1:0]      amp0_reg, amp1_reg;
    logic signed [SINE_W-1:0]     sin_value, sin1_reg;
    logic signed [PROD_W-1:0]     prod2_reg;
    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic signed [SUM_W-1:0]      rnd_sum;
    logic signed [SH_W-1:0]       shifted;
    logic signed [SAMPLE_W-1:0]   sample_reg, sample_next;

    // Tone words: written from the configuration port, ignored beyond the list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TONES; i++)
            begin
                tone_word_reg[i] <= WORD_RESET;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_TONES; i++)
            begin
                if (cfg_wr && (i < NUM_TONE_WORDS) &&
                    (cfg_index == CFG_INDEX_W'(int'(REG_TONE0) + i)))
                begin
                    tone_word_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Phase accumulators: cleared on restart, all advanced once per sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TONES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_TONES; i++)
            begin
                if (cmd.clear_acc)
                begin
                    acc_reg[i] <= '0;
                end
                else if (cmd.advance)
                begin
                    acc_reg[i] <= acc_reg[i] +
                                  ACC_BITS'(tone_word_reg[i][TUNE_LSB +: TUNE_W]);
                end
            end
        end
    end

    // Angle of the tone being issued: accumulator, phase offset and cosine quarter turn.
    always_comb
    begin
        sel_word = tone_word_reg[tone_idx];
        angle = acc_reg[tone_idx] +
                (ACC_BITS'(sel_word[PHASE_LSB +: PHASE_W]) << (ACC_BITS - PHASE_W)) +
                (sel_word[COS_BIT] ? QTR_TURN : '0);
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= cmd.issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    mts_sine_lut #(
        .TABLE_BITS(TABLE_BITS)
    ) u_sine_lut (
        .idx  (idx0_reg),
        .value(sin_value)
    );

    // Sum of products, cleared at the start of each sample.
    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.start)
        begin
            sum_next = '0;
        end
        else if (v2_reg)
        begin
            sum_next = sum_reg + SUM_W'(prod2_reg);
        end
    end

    // Round half up to Q.8 and saturate to the output range.
    always_comb
    begin
        rnd_sum = sum_reg + RND;
        shifted = rnd_sum[SUM_W-1:FRAC_SHIFT];
        if (shifted > SAT_HI)
        begin
            sample_next = SAMPLE_W'(SAT_HI);
        end
        else if (shifted < SAT_LO)
        begin
            sample_next = SAMPLE_W'(SAT_LO);
        end
        else
        begin
            sample_next = SAMPLE_W'(shifted);
        end
    end

    // Payload stages: index, table value, product, running sum, output sample.
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            idx0_reg <= angle[ACC_BITS-1 -: TABLE_BITS];
            amp0_reg <= sel_word[AMP_W-1:0];
        end
        sin1_reg  <= sin_value;
        amp1_reg  <= amp0_reg;
        prod2_reg <= amp1_reg * sin1_reg;
        sum_reg   <= sum_next;
        if (cmd.load_out)
        begin
            sample_reg <= sample_next;
        end
    end

    assign status.busy = v0_reg | v1_reg | v2_reg;
    assign sample      = sample_reg;

    `MTS_ASSERT_IMP(a_start_empty, cmd.start, !status.busy, "sample started with pipeline busy")
    `MTS_ASSERT_IMP(a_load_empty, cmd.load_out, !status.busy, "sample loaded before last product")
    `MTS_ASSERT_IMP(a_prod_order, v2_reg, $past(v1_reg), "product valid without lookup stage")

endmodule

// File: hw/rtl/mts_ctrl.sv
// Controller: input handshake, tone sequencing, output valid and the tone count register.
// Depends on mts_pkg and the assertion macro header.
`include "multi_tone_sine_synthesizer_macros.svh"

module mts_ctrl #(
    parameter int MAX_TONES = mts_pkg::DEF_MAX_TONES,
    parameter int TI_W      = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr,
    input  logic [mts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_stall,
    output mts_pkg::mts_cmd_t               cmd,
    output logic [TI_W-1:0]                 tone_idx,
    input  mts_pkg::mts_status_t            status
);
    import mts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } state_t;

    state_t             state_reg, state_next;
    logic [TI_W-1:0]    tone_idx_reg, tone_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] tone_count_reg;
    logic [TI_W-1:0]    last_tone;
    logic               in_accept;
    logic               last_issue;

    // Tone count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_count_reg <= COUNT_RESET;
        end
        else if (cfg_wr && (cfg_index == REG_TONE_COUNT))
        begin
            tone_count_reg <= cfg_data[COUNT_W-1:0];
        end
    end

    // Index of the last active tone: a count of zero means one, capped at MAX_TONES.
    always_comb
    begin
        int cnt;
        cnt = int'(tone_count_reg);
        if (cnt == 0)
        begin
            cnt = 1;
        end
        if (cnt > MAX_TONES)
        begin
            cnt = MAX_TONES;
        end
        last_tone = TI_W'(cnt - 1);
    end

    // Commands to the datapath.
    always_comb
    begin
        in_accept     = in_valid && (state_reg == S_IDLE);
        last_issue    = (state_reg == S_ISSUE) && (tone_idx_reg == last_tone);
        cmd.start     = in_accept;
        cmd.clear_acc = in_accept && restart;
        cmd.issue     = (state_reg == S_ISSUE);
        cmd.advance   = last_issue;
        cmd.load_out  = (state_reg == S_DRAIN) && !status.busy &&
                        (!out_valid_reg || !out_stall);
    end

    // Next state, tone counter and output valid.
    always_comb
    begin
        state_next     = state_reg;
        tone_idx_next  = tone_idx_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next    = S_ISSUE;
                    tone_idx_next = '0;
                end
            end
            S_ISSUE:
            begin
                if (last_issue)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    tone_idx_next = tone_idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (cmd.load_out)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tone_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tone_idx_reg  <= tone_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign tone_idx  = tone_idx_reg;

    `MTS_ASSERT_NXT(a_accept_issue, in_accept,
                    (state_reg == S_ISSUE) && (tone_idx_reg == '0),
                    "accepted beat did not start at the first tone")
    `MTS_ASSERT_IMP(a_no_overwrite, out_valid_reg && out_stall, !cmd.load_out,
                    "held sample overwritten")
    `MTS_ASSERT_NXT(a_load_valid, cmd.load_out, out_valid_reg, "loaded sample not presented")

endmodule

// File: hw/rtl/multi_tone_sine_synthesizer.sv
// Multi-tone sine synthesizer top level: one output beat per input beat.
// A new beat is taken only after the previous sample is loaded into the output register:
// one shared table lookup and multiplier take one tone per cycle, followed by a
// three-stage lookup/multiply/accumulate drain and rounding.
// Reset (asynchronous, active low) gives one tone, unit-amplitude sine, zero phase accumulators.
// Depends on mts_pkg, mts_ctrl and mts_dp.
module multi_tone_sine_synthesizer #(
    parameter int MAX_TONES  = mts_pkg::DEF_MAX_TONES,
    parameter int TABLE_BITS = mts_pkg::DEF_TABLE_BITS,
    parameter int ACC_BITS   = mts_pkg::DEF_ACC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [mts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mts_pkg::SAMPLE_W-1:0] sample
);
    import mts_pkg::*;

    localparam int TI_W = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;

    mts_cmd_t        cmd;
    mts_status_t     status;
    logic [TI_W-1:0] tone_idx;

    mts_ctrl #(
        .MAX_TONES(MAX_TONES),
        .TI_W     (TI_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .restart  (restart),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd      (cmd),
        .tone_idx (tone_idx),
        .status   (status)
    );

    mts_dp #(
        .MAX_TONES (MAX_TONES),
        .TABLE_BITS(TABLE_BITS),
        .ACC_BITS  (ACC_BITS),
        .TI_W      (TI_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .tone_idx (tone_idx),
        .status   (status),
        .sample   (sample)
    );

endmodule

// File: bench/mts_sample_checker.sv
// Checker for the multi-tone synthesizer: follows register writes, predicts each output sample
// from the accepted input beats and compares it with the sample the block delivers.
// Depends on mts_pkg for port widths, register indexes and tone word layout.
module mts_sample_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [mts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                restart,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [mts_pkg::SAMPLE_W-1:0] sample,
    output int                                  errors,
    output int                                  pending
);
    import mts_pkg::*;

    localparam int TONES    = DEF_MAX_TONES;
    localparam int TBL_BITS = DEF_TABLE_BITS;
    localparam int ACC_W    = DEF_ACC_BITS;
    localparam int TBL_SIZE = 1 << TBL_BITS;
    localparam int QTR_SIZE = TBL_SIZE / 4;

    int                         sine_lut [TBL_SIZE];
    logic [COUNT_W-1:0]         tone_count_q;
    logic [CFG_DATA_W-1:0]      tone_word_q [TONES];
    logic [ACC_W-1:0]           phase_q [TONES];
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] want;
    int                         err_count;
    int                         out_beats;

    assign errors = err_count;

    // Sine of j/TBL_SIZE turn in Q1.14 for the first quarter, by a Taylor series in Q2.30.
    function automatic int quarter_wave(input int unsigned j);
        longint unsigned x;
        longint unsigned term;
        longint          series;
        longint          v;
        int              n;
        x      = (PI_Q30 * 64'd2 * longint'(j)) >> TBL_BITS;
        term   = x;
        series = longint'(x);
        for (n = 1; n <= 10; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                series = series - longint'(term);
            end
            else
            begin
                series = series + longint'(term);
            end
        end
        if (series < 0)
        begin
            series = 0;
        end
        v = (series + 32768) >>> 16;
        if (v > 16384)
        begin
            v = 16384;
        end
        return int'(v);
    endfunction

    // On clear zero the phases; form one sample from the tone settings, then step every accumulator.
    function automatic logic signed [SAMPLE_W-1:0] next_sample(input logic clear);
        int                       active;
        int                       i;
        longint                   total;
        logic [ACC_W-1:0]         angle;
        logic [CFG_DATA_W-1:0]    w;
        logic signed [AMP_W-1:0]  amp;
        if (clear)
        begin
            for (i = 0; i < TONES; i++)
            begin
                phase_q[i] = '0;
            end
        end
        active = int'(tone_count_q);
        if (active == 0)
        begin
            active = 1;
        end
        if (active > TONES)
        begin
            active = TONES;
        end
        total = 0;
        for (i = 0; i < active; i++)
        begin
            w     = tone_word_q[i];
            amp   = w[0 +: AMP_W];
            angle = phase_q[i] + (ACC_W'(w[PHASE_LSB +: PHASE_W]) << (ACC_W - PHASE_W));
            if (w[COS_BIT])
            begin
                angle = angle + (ACC_W'(1) << (ACC_W - 2));
            end
            total = total + longint'(amp) * longint'(sine_lut[angle[ACC_W-1 -: TBL_BITS]]);
        end
        for (i = 0; i < TONES; i++)
        begin
            phase_q[i] = phase_q[i] + tone_word_q[i][TUNE_LSB +: TUNE_W];
        end
        // Round half up to Q.8, then clamp to the sample range.
        total = (total + ROUND_HALF) >>> FRAC_SHIFT;
        if (total > SAMPLE_MAX)
        begin
            total = SAMPLE_MAX;
        end
        if (total < SAMPLE_MIN)
        begin
            total = SAMPLE_MIN;
        end
        return SAMPLE_W'(total);
    endfunction

    task automatic report_error(input string msg);
        $display("%s", msg);
        err_count++;
    endtask

    // Full sine table from the quarter wave by symmetry.
    initial
    begin
        int k;
        int v;
        err_count = 0;
        for (k = 0; k < TBL_SIZE; k++)
        begin
            if ((k / QTR_SIZE) % 2 == 1)
            begin
                v = quarter_wave(QTR_SIZE - (k % QTR_SIZE));
            end
            else
            begin
                v = quarter_wave(k % QTR_SIZE);
            end
            sine_lut[k] = ((k / QTR_SIZE) >= 2) ? -v : v;
        end
    end

    // Track writes, score output beats against the oldest prediction, queue new ones.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_count_q = COUNT_RESET;
            for (int t = 0; t < TONES; t++)
            begin
                tone_word_q[t] = WORD_RESET;
                phase_q[t]     = '0;
            end
            expected_samples.delete();
            out_beats = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (cfg_index == REG_TONE_COUNT)
                begin
                    tone_count_q = cfg_data[COUNT_W-1:0];
                end
                else if (cfg_index >= REG_TONE0 && cfg_index < REG_TONE0 + NUM_TONE_WORDS)
                begin
                    tone_word_q[int'(cfg_index - REG_TONE0)] = cfg_data;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    report_error($sformatf("sample beat %0d: none expected, got %0d",
                                           out_beats, sample));
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample !== want)
                    begin
                        report_error($sformatf("sample beat %0d: got %0d, want %0d",
                                               out_beats, sample, want));
                    end
                end
                out_beats++;
            end
            if (in_valid && !in_stall)
            begin
                expected_samples.push_back(next_sample(restart));
            end
            pending <= expected_samples.size();
        end
    end

endmodule

// File: bench/tb_multi_tone_sine_synthesizer.sv
// Testbench top for the multi-tone synthesizer: drives register settings and restart beats,
// applies random input gaps and random sample stalls, and gives the verdict.
// Depends on mts_pkg, multi_tone_sine_synthesizer and mts_sample_checker.
module tb_multi_tone_sine_synthesizer;
    import mts_pkg::*;

    localparam int REG_SPAN  = 1 << CFG_INDEX_W;
    localparam int SEGMENTS  = 23;
    localparam int SEG_BEATS = 50;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       restart;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    int                         errors;
    int                         pending;
    int                         tick_gap_pct = 13;
    int                         sample_hold_pct = 88;
    logic [CFG_DATA_W-1:0]      tone_cfg [NUM_TONE_WORDS];

    multi_tone_sine_synthesizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

    mts_sample_checker u_sample_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Random back-pressure on the sample channel.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < sample_hold_pct);
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(12 * 600000);
        $display("multi_tone_sine_synthesizer: mismatch");
        $finish;
    end

    function automatic logic [CFG_DATA_W-1:0] tone_word(input logic cosine,
                                                        input logic [PHASE_W-1:0] phase,
                                                        input logic [TUNE_W-1:0] tune,
                                                        input logic [AMP_W-1:0] amp);
        logic [CFG_DATA_W-1:0] w;
        w                        = '0;
        w[COS_BIT]               = cosine;
        w[PHASE_LSB +: PHASE_W]  = phase;
        w[TUNE_LSB +: TUNE_W]    = tune;
        w[0 +: AMP_W]            = amp;
        return w;
    endfunction

    // Random tone word, with full-scale amplitudes and slow tuning mixed in.
    function automatic logic [CFG_DATA_W-1:0] rand_tone();
        logic [63:0]           bits;
        logic [CFG_DATA_W-1:0] w;
        bits = {$urandom, $urandom};
        w    = bits[CFG_DATA_W-1:0];
        case ($urandom_range(0, 5))
            0: w[0 +: AMP_W] = 16'h7FFF;
            1: w[0 +: AMP_W] = 16'h8000;
            2: w[TUNE_LSB +: TUNE_W] = TUNE_W'($urandom_range(0, 4095));
            default: ;
        endcase
        return w;
    endfunction

    // Offer one input beat after a random gap and hold it until accepted.
    task automatic send_beat(input logic clear);
        while ($urandom_range(0, 99) < tick_gap_pct)
        begin
            in_valid <= 1'b0;
            restart  <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= clear;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted sample has been delivered.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    // Write the tone count and all tone words; optionally poke the unused indexes too.
    task automatic write_settings(input logic [COUNT_W-1:0] count, input logic poke_unused);
        logic [63:0] bits;
        int          k;
        bits = {$urandom, $urandom};
        cfg_wr    <= 1'b1;
        cfg_index <= REG_TONE_COUNT;
        cfg_data  <= {bits[CFG_DATA_W-1:COUNT_W], count};
        @(posedge clk);
        for (k = 0; k < NUM_TONE_WORDS; k++)
        begin
            cfg_index <= REG_TONE0 + CFG_INDEX_W'(k);
            cfg_data  <= tone_cfg[k];
            @(posedge clk);
        end
        if (poke_unused)
        begin
            for (k = int'(REG_TONE0) + NUM_TONE_WORDS; k < REG_SPAN; k++)
            begin
                bits = {$urandom, $urandom};
                cfg_index <= CFG_INDEX_W'(k);
                cfg_data  <= bits[CFG_DATA_W-1:0];
                @(posedge clk);
            end
        end
        cfg_wr <= 1'b0;
    endtask

    initial
    begin
        int seg;
        int n;
        int t;
        rst_n     = 1'b0;
        cfg_wr    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings after reset, then a restart of the running accumulator.
        for (n = 0; n < 3; n++)
        begin
            send_beat(1'b0);
        end
        send_beat(1'b1);
        wait_idle();

        // Four tones at full scale, extreme phases and tunings, sine and cosine.
        tone_cfg[0] = tone_word(1'b0, 16'h0000, 24'hFFFFFF, 16'h7FFF);
        tone_cfg[1] = tone_word(1'b1, 16'hFFFF, 24'h000000, 16'h8000);
        tone_cfg[2] = tone_word(1'b1, 16'h4000, 24'h123456, 16'h7FFF);
        tone_cfg[3] = tone_word(1'b0, 16'hC000, 24'h800000, 16'h8000);
        write_settings(3'd4, 1'b0);
        for (n = 0; n < 6; n++)
        begin
            send_beat(n == 2);
        end
        wait_idle();

        // A zero tone count acts as one tone; writes past the last register do nothing.
        tone_cfg[0] = '1;
        for (t = 1; t < NUM_TONE_WORDS; t++)
        begin
            tone_cfg[t] = '0;
        end
        write_settings(3'd0, 1'b1);
        for (n = 0; n < 4; n++)
        begin
            send_beat(n == 0);
        end
        wait_idle();

        // Counts above the tone limit, with every tone at the largest positive sum.
        for (t = 0; t < NUM_TONE_WORDS; t++)
        begin
            tone_cfg[t] = tone_word(1'b1, 16'h0000, 24'h000000, 16'h7FFF);
        end
        write_settings(3'd7, 1'b0);
        for (n = 0; n < 3; n++)
        begin
            send_beat(1'b0);
        end
        wait_idle();

        // Most negative amplitude on every tone.
        for (t = 0; t < NUM_TONE_WORDS; t++)
        begin
            tone_cfg[t] = tone_word(1'b1, 16'h0000, 24'h000000, 16'h8000);
        end
        write_settings(3'd5, 1'b0);
        for (n = 0; n < 3; n++)
        begin
            send_beat(1'b0);
        end
        wait_idle();

        // Random settings, each followed by a run of beats with occasional restarts.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 8)
            begin
                tick_gap_pct    = 13;
                sample_hold_pct = 88;
            end
            else if (seg < 16)
            begin
                tick_gap_pct    = 88;
                sample_hold_pct = 13;
            end
            else
            begin
                tick_gap_pct    = 0;
                sample_hold_pct = 0;
            end
            for (t = 0; t < NUM_TONE_WORDS; t++)
            begin
                tone_cfg[t] = rand_tone();
            end
            write_settings(COUNT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            for (n = 0; n < SEG_BEATS; n++)
            begin
                send_beat($urandom_range(0, 7) == 0);
            end
            wait_idle();
        end

        if (errors == 0 && pending == 0)
        begin
            $display("multi_tone_sine_synthesizer: match");
        end
        else
        begin
            $display("multi_tone_sine_synthesizer: mismatch");
        end
        $finish;
    end

endmodule
